>>> rtl/fpga_serial_config_loader_defines.svh
// Assertion macros for the checker file of the configuration loader.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef FPGA_SERIAL_CONFIG_LOADER_DEFINES_SVH
`define FPGA_SERIAL_CONFIG_LOADER_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define FSCL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fscl check failed");

// next-cycle implication
`define FSCL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fscl check failed");

`endif

>>> rtl/fscl_pkg.sv
// Types and constants of the serial configuration loader.
// No dependencies; used by the core, the top level and the checker.
package fscl_pkg;

	localparam int BYTES_W    = 24;
	localparam int TIMEOUT_W  = 16;
	localparam int CLOCKS_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [1:0] {
		CMD_PROGRAM = 2'd0,
		CMD_TICK    = 2'd1,
		CMD_DATA    = 2'd2,
		CMD_FINISH  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_WAIT   = 3'd1,
		PH_READY  = 3'd2,
		PH_LOADED = 3'd3,
		PH_ERROR  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_INIT_LOW = 2'd1,
		ERR_COUNT    = 2'd2
	} err_t;

	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_BYTES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_CLOCKS = 2'd2;

	localparam logic [BYTES_W-1:0]   EXPECTED_RESET = 24'd0;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd1000;
	localparam logic [CLOCKS_W-1:0]  STARTUP_RESET  = 8'd128;
	localparam logic [CLOCKS_W-1:0]  BIT_CLOCKS     = 8'h01;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data_byte;
		logic       init_line;
	} item_t;

	typedef struct packed {
		logic [BYTES_W-1:0]   expected_bytes;
		logic [TIMEOUT_W-1:0] init_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		phase_t             phase;
		err_t               error_code;
		logic [BYTES_W-1:0] bytes_loaded;
	} status_t;

endpackage

>>> rtl/fscl_core.sv
// Load state of the configuration loader: phase, init timeout, byte count, fault.
// Depends on fscl_pkg; reports the status as it stands after the item applied.
module fscl_core #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              apply,
	input  fscl_pkg::item_t   item,
	input  fscl_pkg::cfg_t    cfg,
	output fscl_pkg::status_t status
);

	localparam int CMP_W = (COUNT_WIDTH > fscl_pkg::BYTES_W) ? COUNT_WIDTH : fscl_pkg::BYTES_W;

	fscl_pkg::phase_t                   phase_q, phase_d;
	fscl_pkg::err_t                     fault_q, fault_d;
	logic [fscl_pkg::TIMEOUT_W-1:0]     wait_left_q, wait_left_d;
	logic [COUNT_WIDTH-1:0]             total_q, total_d;
	logic [CMP_W-1:0]                   total_ext;

	always_comb begin
		phase_d     = phase_q;
		fault_d     = fault_q;
		wait_left_d = wait_left_q;
		total_d     = total_q;
		unique case (item.cmd)
			fscl_pkg::CMD_PROGRAM: begin
				total_d     = '0;
				wait_left_d = cfg.init_timeout_ticks;
				fault_d     = fscl_pkg::ERR_NONE;
				phase_d     = fscl_pkg::PH_WAIT;
			end
			fscl_pkg::CMD_TICK: begin
				if (phase_q == fscl_pkg::PH_WAIT) begin
					if (item.init_line) begin
						phase_d = fscl_pkg::PH_READY;
					end else if (wait_left_q == '0) begin
						phase_d = fscl_pkg::PH_ERROR;
						fault_d = fscl_pkg::ERR_INIT_LOW;
					end else begin
						wait_left_d = wait_left_q - 16'd1;
					end
				end
			end
			fscl_pkg::CMD_DATA: begin
				// saturate at all ones
				if (total_q != '1) begin
					total_d = total_q + COUNT_WIDTH'(1);
				end
			end
			fscl_pkg::CMD_FINISH: begin
				// a low init line outranks a count mismatch
				if (!item.init_line) begin
					phase_d = fscl_pkg::PH_ERROR;
					fault_d = fscl_pkg::ERR_INIT_LOW;
				end else if (CMP_W'(total_q) != CMP_W'(cfg.expected_bytes)) begin
					phase_d = fscl_pkg::PH_ERROR;
					fault_d = fscl_pkg::ERR_COUNT;
				end else begin
					phase_d = fscl_pkg::PH_LOADED;
					fault_d = fscl_pkg::ERR_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= fscl_pkg::PH_IDLE;
			fault_q     <= fscl_pkg::ERR_NONE;
			wait_left_q <= '0;
			total_q     <= '0;
		end else if (apply) begin
			phase_q     <= phase_d;
			fault_q     <= fault_d;
			wait_left_q <= wait_left_d;
			total_q     <= total_d;
		end
	end

	assign total_ext = CMP_W'(total_d);

	assign status.phase        = phase_d;
	assign status.error_code   = fault_d;
	assign status.bytes_loaded = total_ext[fscl_pkg::BYTES_W-1:0];

endmodule

>>> rtl/fpga_serial_config_loader.sv
// Top level of the slave-serial configuration loader: input register, config
// registers, result register with bit serializer. Depends on fscl_pkg, fscl_core.
//
// Usage:
//   Requests enter on in_valid/in_ready (command, data_byte, init_line) and
//   results leave on out_valid/out_ready. Configuration is written through
//   cfg_we/cfg_index/cfg_data, one register per cycle, while the block is idle;
//   an unknown index is ignored.
//   An accepted request moves on into the result register once that is free.
//   Program, tick and finish give one result each; a data byte gives eight
//   results, one serial bit per cycle while out_ready is high, most significant
//   first, the eighth marked last. The result register sends one result per
//   cycle while out_ready is high, so program, tick and finish run at one
//   request per cycle; a data byte sends all eight results first.
//   The input register takes the next request while a result waits, and the
//   state update of a request happens as it moves into the result register.
//   When out_ready is low the result register holds and, once the input
//   register is full too, in_ready drops.
//   Reset empties both registers, sets the phase to idle with no fault, a zero
//   byte count and timeout, and loads the register defaults (expected 0,
//   timeout 1000 ticks, 128 startup clocks).
module fpga_serial_config_loader #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fscl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fscl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      command,
	input  logic [7:0]                      data_byte,
	input  logic                            init_line,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            program_pulse,
	output logic                            data_line,
	output logic [7:0]                      clock_pulses,
	output logic                            last,
	output logic [2:0]                      phase,
	output logic [1:0]                      error_code,
	output logic [fscl_pkg::BYTES_W-1:0]    bytes_loaded
);

	fscl_pkg::cfg_t                 cfg_q;
	logic [fscl_pkg::CLOCKS_W-1:0]  startup_q;

	fscl_pkg::item_t   item_s1;
	logic              valid_s1;

	logic              valid_s2;
	logic              prog_s2;
	logic [7:0]        shift_s2;
	logic [7:0]        clocks_s2;
	logic [2:0]        left_s2;
	fscl_pkg::status_t status_s2;

	fscl_pkg::status_t status_next;
	logic              s2_free;
	logic              advance;

	assign s2_free  = !valid_s2 || (out_ready && (left_s2 == 3'd0));
	assign advance  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_bytes     <= fscl_pkg::EXPECTED_RESET;
			cfg_q.init_timeout_ticks <= fscl_pkg::TIMEOUT_RESET;
			startup_q                <= fscl_pkg::STARTUP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fscl_pkg::REG_EXPECTED_BYTES: cfg_q.expected_bytes <= cfg_data;
				fscl_pkg::REG_INIT_TIMEOUT:
					cfg_q.init_timeout_ticks <= cfg_data[fscl_pkg::TIMEOUT_W-1:0];
				fscl_pkg::REG_STARTUP_CLOCKS: startup_q <= cfg_data[fscl_pkg::CLOCKS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.cmd       <= fscl_pkg::cmd_t'(command);
			item_s1.data_byte <= data_byte;
			item_s1.init_line <= init_line;
		end
	end

	fscl_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.apply (advance),
		.item  (item_s1),
		.cfg   (cfg_q),
		.status(status_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			left_s2  <= 3'd0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			left_s2  <= (item_s1.cmd == fscl_pkg::CMD_DATA) ? 3'd7 : 3'd0;
		end else if (valid_s2 && out_ready) begin
			// drop after the last bit, otherwise advance one bit
			if (left_s2 == 3'd0) begin
				valid_s2 <= 1'b0;
			end else begin
				left_s2 <= left_s2 - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2 <= status_next;
			prog_s2   <= (item_s1.cmd == fscl_pkg::CMD_PROGRAM);
			case (item_s1.cmd)
				fscl_pkg::CMD_DATA: begin
					shift_s2  <= item_s1.data_byte;
					clocks_s2 <= fscl_pkg::BIT_CLOCKS;
				end
				fscl_pkg::CMD_FINISH: begin
					shift_s2  <= 8'h80;
					clocks_s2 <= startup_q;
				end
				default: begin
					shift_s2  <= 8'h00;
					clocks_s2 <= 8'h00;
				end
			endcase
		end else if (valid_s2 && out_ready && (left_s2 != 3'd0)) begin
			shift_s2 <= {shift_s2[6:0], 1'b0};
		end
	end

	assign out_valid     = valid_s2;
	assign program_pulse = prog_s2;
	assign data_line     = shift_s2[7];
	assign clock_pulses  = clocks_s2;
	assign last          = (left_s2 == 3'd0);
	assign phase         = status_s2.phase;
	assign error_code    = status_s2.error_code;
	assign bytes_loaded  = status_s2.bytes_loaded;

endmodule

>>> rtl/fscl_checker.sv
// Port-level checks of the configuration loader, bound to the top level.
// Depends on fscl_pkg and fpga_serial_config_loader_defines.svh.
`include "fpga_serial_config_loader_defines.svh"

module fscl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         program_pulse,
	input logic                         data_line,
	input logic [7:0]                   clock_pulses,
	input logic                         last,
	input logic [2:0]                   phase,
	input logic [1:0]                   error_code,
	input logic [fscl_pkg::BYTES_W-1:0] bytes_loaded
);

	// a program result restarts the load from scratch
	`FSCL_ASSERT_NOW(a_program_result, out_valid && program_pulse, last && !data_line && (clock_pulses == 8'd0) && (bytes_loaded == '0) && (phase == fscl_pkg::PH_WAIT) && (error_code == fscl_pkg::ERR_NONE))

	// a fault code is shown exactly in the error phase
	`FSCL_ASSERT_NOW(a_fault_in_error, out_valid, (phase == fscl_pkg::PH_ERROR) == (error_code != fscl_pkg::ERR_NONE))

	// inside a byte: one clock per bit, the next bit follows with unchanged status
	`FSCL_ASSERT_NEXT(a_byte_continues, out_valid && out_ready && !last, out_valid && !program_pulse && (clock_pulses == 8'd1) && $stable(bytes_loaded) && $stable(phase) && $stable(error_code))

	// a stalled result holds
	`FSCL_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(data_line) && $stable(last) && $stable(clock_pulses))

endmodule

bind fpga_serial_config_loader fscl_checker u_fscl_checker (.*);
